// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the interpolator RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants for the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_POINTS = 1'b1;

  // edge handling modes; anything else clamps
  localparam logic [2:0] MODE_EXTRAP_BOTH  = 3'd1;
  localparam logic [2:0] MODE_SLOPE_ONE    = 3'd2;
  localparam logic [2:0] MODE_STEP         = 3'd3;
  localparam logic [2:0] MODE_EXTRAP_RIGHT = 3'd4;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // divider geometry: quotient bits 34..0, overflow above 2**34
  localparam int QW = 35;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_FIRST,
    ST_LD_LEFT2,
    ST_LD_LAST,
    ST_LD_PREV,
    ST_SCAN,
    ST_PREP,
    ST_WAIT,
    ST_SUM,
    ST_RESULT
  } pli_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic        start;
    logic [32:0] mag_a;
    logic [32:0] mag_b;
    logic [32:0] den;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } md_status_t;

endpackage

// ----- src/pli_table.sv -----
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint store: one write port, one registered read port, x and y side
// by side in each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_table #(
  parameter int POINTS = 64,
  parameter int AW     = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [31:0]  wr_x,
  input  logic signed [31:0]  wr_y,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic signed [31:0]  rd_x,
  output logic signed [31:0]  rd_y
);

  logic [63:0] mem [POINTS];
  logic [63:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_x = rd_word[63:32];
  assign rd_y = rd_word[31:0];

endmodule

// ----- src/pli_muldiv.sv -----
// ----------------------------------------------------------------------------
// pli_muldiv
// Shared slope unit: one 33x33 multiply, then a restoring shift-subtract
// divide producing one quotient bit a cycle. Quotients of 2**35 or more are
// flagged as overflow before the divide starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pli_muldiv
  import pli_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  md_req_t       req,
  output md_status_t    stat,
  output logic [QW-1:0] q
);

  md_state_t   md_state;
  md_state_t   md_state_next;
  logic [32:0] a;
  logic [32:0] b;
  logic [32:0] den;
  logic [65:0] prod;
  logic [65:0] rem;
  logic [66:0] dv;
  logic [5:0]  step;
  logic        done;
  logic        ovf;
  logic        too_big;
  logic        sub_ok;

  assign too_big = ({2'b00, prod} >= {den, 35'b0});
  assign sub_ok  = ({1'b0, rem} >= dv);

  always_comb begin
    md_state_next = md_state;
    unique case (md_state)
      MD_IDLE: begin
        if (req.start) md_state_next = MD_MUL;
      end
      MD_MUL: md_state_next = MD_CHK;
      MD_CHK: begin
        md_state_next = too_big ? MD_IDLE : MD_DIV;
      end
      MD_DIV: begin
        if (step == 6'd0) md_state_next = MD_IDLE;
      end
      default: md_state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      md_state <= MD_IDLE;
      done     <= 1'b0;
    end else begin
      md_state <= md_state_next;
      done     <= ((md_state == MD_CHK) && too_big) ||
                  ((md_state == MD_DIV) && (step == 6'd0));
    end
  end

  always_ff @(posedge clk) begin
    case (md_state)
      MD_IDLE: begin
        if (req.start) begin
          a   <= req.mag_a;
          b   <= req.mag_b;
          den <= req.den;
        end
      end
      MD_MUL: prod <= a * b;
      MD_CHK: begin
        ovf  <= too_big;
        rem  <= prod;
        dv   <= {den, 34'b0};
        q    <= '0;
        step <= 6'(QW - 1);
      end
      MD_DIV: begin
        if (sub_ok) begin
          rem <= rem - dv[65:0];
        end
        q    <= {q[QW-2:0], sub_ok};
        dv   <= dv >> 1;
        step <= step - 6'd1;
      end
      default: ;
    endcase
  end

  assign stat.busy = (md_state != MD_IDLE);
  assign stat.done = done;
  assign stat.ovf  = ovf;

  // remainder stays below twice the current divisor step
  `ASSERT_IMP(a_md_rem_bound, clk, rst, md_state == MD_DIV, ({2'b00, rem} < {dv, 1'b0}))
  `ASSERT_IMP(a_md_start_idle, clk, rst, req.start, md_state == MD_IDLE)
  `ASSERT_NXT(a_md_done_end, clk, rst, (md_state == MD_DIV) && (step == 6'd0), done)

endmodule

// ----- src/piecewise_linear_table_interp.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Q16.16 breakpoint table with linear interpolation and mode-selected edge
// handling. Writes fill the table; queries return one saturated result.
//
//   channel   signals                                         direction
//   in        in_valid/in_ready, req_type, point_index,       to block
//             point_x, point_y, query_x
//   out       out_valid/out_ready, y_value, saturated,        from block
//             no_segment
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data        to block
//
// A write goes into the table while the sequencer stays idle. A query with no line
// to evaluate passes through the load states and, for a point inside the table, scans
// one entry a cycle through the single read port. A line adds the start state, the
// wait on the slope unit (multiply, overflow check, 35-bit divide, done) and the final
// sum. Only mode, count and handshake state are reset. A result waiting on out_ready
// holds the sequencer, and in_ready stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piecewise_linear_table_interp
  import pli_pkg::*;
#(
  parameter int POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] y_value,
  output logic               saturated,
  output logic               no_segment,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int AW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS + 1);

  pli_state_t         state;
  pli_state_t         state_next;
  logic [2:0]         mode;
  logic [6:0]         points_in_use;
  logic signed [31:0] qx;
  logic [CW-1:0]      n_cnt;
  logic [CW-1:0]      n_clip;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      prev_idx;
  logic [AW-1:0]      cnt;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic               neg;
  logic signed [31:0] fin_base;
  logic signed [36:0] fin_off;
  logic signed [31:0] r_y;
  logic               r_sat;
  logic               r_nos;

  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;

  logic               q_take;
  logic               left_hit;
  logic               right_hit;
  logic               seg_hit;
  logic               is_step;
  logic               out_load;
  logic               slope_ovf;
  logic [32:0]        dy;
  logic [32:0]        dx;
  logic [32:0]        w;
  logic signed [37:0] sum;
  md_req_t            md_req;
  md_status_t         md_stat;
  logic [QW-1:0]      md_q;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign q_take    = in_valid && in_ready && (req_type == REQ_QUERY);
  assign wr_en     = in_valid && in_ready && (req_type == REQ_WRITE) &&
                     (32'(point_index) < 32'(POINTS));

  assign n_clip = (32'(points_in_use) > 32'(POINTS)) ? CW'(POINTS) : CW'(points_in_use);

  assign is_step   = (mode == MODE_STEP);
  assign left_hit  = (qx <= rd_x);
  assign right_hit = (qx >= rd_x);
  assign seg_hit   = (qx >= ax) && (qx <= rd_x);
  assign out_load  = (state == ST_RESULT) && (!out_valid || out_ready);

  // slope operands
  assign dy = {by[31], by} - {ay[31], ay};
  assign dx = {qx[31], qx} - {ax[31], ax};
  assign w  = {bx[31], bx} - {ax[31], ax};

  assign md_req.start = (state == ST_PREP);
  assign md_req.mag_a = dy[32] ? -dy : dy;
  assign md_req.mag_b = dx[32] ? -dx : dx;
  assign md_req.den   = w[32] ? -w : w;

  assign slope_ovf = md_stat.ovf || (md_q[QW-1] && (|md_q[QW-2:0]));
  assign sum = {{6{fin_base[31]}}, fin_base} + {fin_off[36], fin_off};

  pli_table #(
    .POINTS (POINTS),
    .AW     (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(point_index)),
    .wr_x    (point_x),
    .wr_y    (point_y),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pli_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .stat (md_stat),
    .q    (md_q)
  );

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_take) begin
          if (n_clip == '0) begin
            state_next = ST_RESULT;
          end else begin
            rd_en      = 1'b1;
            state_next = ST_LD_FIRST;
          end
        end
      end
      ST_LD_FIRST: begin
        if (n_cnt == CW'(1)) begin
          state_next = ST_RESULT;
        end else if (left_hit) begin
          if (mode == MODE_EXTRAP_BOTH) begin
            rd_en      = 1'b1;
            rd_addr    = AW'(1);
            state_next = ST_LD_LEFT2;
          end else begin
            state_next = ST_RESULT;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = last_idx;
          state_next = ST_LD_LAST;
        end
      end
      ST_LD_LEFT2: begin
        state_next = (rd_x == ax) ? ST_RESULT : ST_PREP;
      end
      ST_LD_LAST: begin
        if (right_hit) begin
          if (is_step && (qx > rd_x)) begin
            state_next = ST_RESULT;
          end else if ((mode == MODE_EXTRAP_BOTH) || (mode == MODE_EXTRAP_RIGHT)) begin
            rd_en      = 1'b1;
            rd_addr    = prev_idx;
            state_next = ST_LD_PREV;
          end else if (mode == MODE_SLOPE_ONE) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_RESULT;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(1);
          state_next = ST_SCAN;
        end
      end
      ST_LD_PREV: begin
        state_next = (rd_x == bx) ? ST_RESULT : ST_PREP;
      end
      ST_SCAN: begin
        if (seg_hit) begin
          state_next = (is_step || (ax == rd_x)) ? ST_RESULT : ST_PREP;
        end else if (cnt == last_idx) begin
          state_next = ST_RESULT;
        end else begin
          // keep the read port streaming one entry ahead
          rd_en   = 1'b1;
          rd_addr = cnt + AW'(1);
        end
      end
      ST_PREP: state_next = ST_WAIT;
      ST_WAIT: begin
        if (md_stat.done) state_next = slope_ovf ? ST_RESULT : ST_SUM;
      end
      ST_SUM: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= 3'd0;
      points_in_use <= 7'd0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:   mode          <= cfg_data[2:0];
          CFG_POINTS: points_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      y_value    <= r_y;
      saturated  <= r_sat;
      no_segment <= r_nos;
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_take) begin
          qx       <= query_x;
          n_cnt    <= n_clip;
          last_idx <= AW'(n_clip - CW'(1));
          prev_idx <= AW'(n_clip - CW'(2));
          r_y      <= '0;
          r_sat    <= 1'b0;
          r_nos    <= 1'b0;
        end
      end
      ST_LD_FIRST: begin
        ax  <= rd_x;
        ay  <= rd_y;
        r_y <= ((n_cnt != CW'(1)) && is_step && (qx < rd_x)) ? '0 : rd_y;
      end
      ST_LD_LEFT2: begin
        bx <= rd_x;
        by <= rd_y;
      end
      ST_LD_LAST: begin
        bx       <= rd_x;
        by       <= rd_y;
        cnt      <= AW'(1);
        r_y      <= (is_step && (qx > rd_x)) ? '0 : rd_y;
        fin_base <= rd_y;
        fin_off  <= {{5{qx[31]}}, qx} - {{5{rd_x[31]}}, rd_x};
      end
      ST_LD_PREV: begin
        ax  <= rd_x;
        ay  <= rd_y;
        r_y <= by;
      end
      ST_SCAN: begin
        if (seg_hit) begin
          bx  <= rd_x;
          by  <= rd_y;
          r_y <= ay;
        end else begin
          ax  <= rd_x;
          ay  <= rd_y;
          cnt <= cnt + AW'(1);
          if (cnt == last_idx) begin
            r_y   <= '0;
            r_nos <= 1'b1;
          end
        end
      end
      ST_PREP: begin
        neg      <= dy[32] ^ dx[32] ^ w[32];
        fin_base <= ay;
      end
      ST_WAIT: begin
        if (md_stat.done) begin
          if (slope_ovf) begin
            r_sat <= 1'b1;
            r_y   <= neg ? Q_MIN : Q_MAX;
          end else begin
            fin_off <= neg ? -{2'b00, md_q} : {2'b00, md_q};
          end
        end
      end
      ST_SUM: begin
        if (sum > 38'(Q_MAX)) begin
          r_y   <= Q_MAX;
          r_sat <= 1'b1;
        end else if (sum < 38'(Q_MIN)) begin
          r_y   <= Q_MIN;
          r_sat <= 1'b1;
        end else begin
          r_y <= sum[31:0];
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_noseg_zero, clk, rst, out_valid && no_segment, (y_value == '0) && !saturated)
  `ASSERT_IMP(a_sat_rail, clk, rst, out_valid && saturated, (y_value == Q_MAX) || (y_value == Q_MIN))
  `ASSERT_NXT(a_done_wait, clk, rst, md_stat.done, (state == ST_SUM) || (state == ST_RESULT))
  `ASSERT_IMP(a_wait_busy, clk, rst, (state == ST_WAIT) && !md_stat.done, md_stat.busy)

endmodule

// ----- tb/interp_result_check.sv -----
// ----------------------------------------------------------------------------
// interp_result_check
// Watches the config, request and result channels of the table interpolator.
// Keeps its own copy of the breakpoint table and edge mode, predicts every
// query result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interp_result_check
  import pli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               req_type,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] y_value,
  input  logic               saturated,
  input  logic               no_segment,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 outstanding,
  output int                 errors
);

  localparam int TABLE_DEPTH = 64;

  typedef struct packed {
    logic signed [31:0] y;
    logic               sat;
    logic               noseg;
  } interp_t;

  logic [2:0] end_mode;
  logic [6:0] point_count;
  longint     x_tab[TABLE_DEPTH];
  longint     y_tab[TABLE_DEPTH];
  interp_t    expected_q[$];
  interp_t    pred;
  interp_t    oldest;
  bit         clip_bit;
  bit         noseg_bit;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic longint clamp_q(input longint v, output bit clip);
    clip = 0;
    if (v > longint'(Q_MAX)) begin
      clip = 1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      clip = 1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  // ya + (yb - ya) * (xq - xa) / (xb - xa), magnitudes, truncated toward zero
  function automatic longint along_segment(input longint xq, input longint xa,
                                           input longint xb, input longint ya,
                                           input longint yb, output bit clip);
    longint          dy;
    longint          dx;
    longint          w;
    longint unsigned mdy;
    longint unsigned mdx;
    longint unsigned mw;
    longint unsigned q;
    bit              neg;
    clip = 0;
    dy   = yb - ya;
    dx   = xq - xa;
    w    = xb - xa;
    neg  = ((dy < 0) != (dx < 0)) != (w < 0);
    mdy  = (dy < 0) ? -dy : dy;
    mdx  = (dx < 0) ? -dx : dx;
    mw   = (w < 0) ? -w : w;
    if (mw == 0) return ya;
    q = (mdy * mdx) / mw;
    // quotient beyond the divider range saturates outright
    if (q > (64'd1 << 34)) begin
      clip = 1;
      return neg ? longint'(Q_MIN) : longint'(Q_MAX);
    end
    return clamp_q(ya + (neg ? -longint'(q) : longint'(q)), clip);
  endfunction

  function automatic longint lookup(input longint xq, output bit clip, output bit noseg);
    int     n;
    longint xf;
    longint xl;
    clip  = 0;
    noseg = 0;
    n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
    if (n == 0) return 0;
    if (n == 1) return y_tab[0];
    xf = x_tab[0];
    xl = x_tab[n-1];
    // left end is checked before the right end
    if (xq <= xf) begin
      if (end_mode == MODE_STEP && xq < xf) return 0;
      if (end_mode == MODE_EXTRAP_BOTH && x_tab[1] != xf)
        return along_segment(xq, xf, x_tab[1], y_tab[0], y_tab[1], clip);
      return y_tab[0];
    end
    if (xq >= xl) begin
      if (end_mode == MODE_STEP && xq > xl) return 0;
      if ((end_mode == MODE_EXTRAP_BOTH || end_mode == MODE_EXTRAP_RIGHT) &&
          x_tab[n-2] != xl)
        return along_segment(xq, x_tab[n-2], xl, y_tab[n-2], y_tab[n-1], clip);
      if (end_mode == MODE_SLOPE_ONE) return clamp_q(y_tab[n-1] + (xq - xl), clip);
      return y_tab[n-1];
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (xq >= x_tab[i] && xq <= x_tab[i+1]) begin
        if (end_mode == MODE_STEP || x_tab[i] == x_tab[i+1]) return y_tab[i];
        return along_segment(xq, x_tab[i], x_tab[i+1], y_tab[i], y_tab[i+1], clip);
      end
    end
    noseg = 1;
    return 0;
  endfunction

  // a result always leaves after its query was taken, so the result
  // side is handled before the request side on a shared edge
  always @(posedge clk) begin
    if (rst) begin
      end_mode    = '0;
      point_count = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) end_mode = cfg_data[2:0];
        else point_count = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no query outstanding, y_value", y_value, 0);
        end else begin
          oldest = expected_q.pop_front();
          if (y_value !== oldest.y) report_mismatch("y_value", y_value, oldest.y);
          if (saturated !== oldest.sat) report_mismatch("saturated", saturated, oldest.sat);
          if (no_segment !== oldest.noseg)
            report_mismatch("no_segment", no_segment, oldest.noseg);
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_WRITE) begin
          x_tab[point_index] = point_x;
          y_tab[point_index] = point_y;
        end else begin
          pred.y     = 32'(lookup(query_x, clip_bit, noseg_bit));
          pred.sat   = clip_bit;
          pred.noseg = noseg_bit;
          expected_q.push_back(pred);
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ----- tb/piecewise_linear_table_interp_tb.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_tb
// Drives breakpoint writes, queries and register writes into the table
// interpolator with random idle and back-pressure; a separate checker predicts
// and compares every result. Directed edge cases first, then random phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_table_interp_tb;
  import pli_pkg::*;

  localparam int         TABLE_DEPTH   = 64;
  localparam int         RANDOM_ITEMS  = 1200;
  // covers the longest query of a full table; a write can still be in flight
  localparam int         SETTLE_CYCLES = 150;
  // room for ~1500 items at their worst, plus phase pauses, several times over
  localparam longint     CYCLE_LIMIT   = 1000000;
  localparam logic [2:0] MODE_CLAMP    = 3'd0;
  localparam logic [2:0] MODE_UNUSED   = 3'd7;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               req_type;
  logic [5:0]         point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] y_value;
  logic               saturated;
  logic               no_segment;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [6:0]         cfg_data;

  int     outstanding;
  int     mismatches;
  bit     tx_calm = 0;
  bit     rx_calm = 0;
  longint cycle_count = 0;
  longint tab_x[TABLE_DEPTH];

  piecewise_linear_table_interp #(.POINTS(TABLE_DEPTH)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .point_index(point_index),
    .point_x    (point_x),
    .point_y    (point_y),
    .query_x    (query_x),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .y_value    (y_value),
    .saturated  (saturated),
    .no_segment (no_segment),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  interp_result_check u_result_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .point_index(point_index),
    .point_x    (point_x),
    .point_y    (point_y),
    .query_x    (query_x),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .y_value    (y_value),
    .saturated  (saturated),
    .no_segment (no_segment),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .errors     (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall after each transfer, none in calm phases
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(negedge rst);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        gap = rx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(input logic rt, input logic [5:0] idx,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] qx);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rt;
    point_index <= idx;
    point_x     <= px;
    point_y     <= py;
    query_x     <= qx;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers in back-to-back transfers, valid held high between them
  task automatic configure(input logic [6:0] mode_word, input logic [6:0] count);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= mode_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_POINTS;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [2:0]         dir_modes[6];
    logic signed [31:0] dir_q[3];
    int                 items_left;
    int                 phase;
    int                 phase_len;
    int                 n_eff;
    int                 step_max;
    int                 pick;
    int                 r;
    logic [6:0]         count;
    logic [2:0]         mode3;
    logic [5:0]         idx;
    longint             xv;
    longint             lo;
    longint             hi;
    longint             span;
    logic signed [31:0] yv;
    logic signed [31:0] px;
    logic signed [31:0] qx;

    dir_modes = '{MODE_CLAMP, MODE_EXTRAP_BOTH, MODE_SLOPE_ONE, MODE_STEP,
                  MODE_EXTRAP_RIGHT, MODE_UNUSED};
    dir_q     = '{Q_MIN, 32'sd0, Q_MAX};

    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= REQ_WRITE;
    point_index <= '0;
    point_x     <= '0;
    point_y     <= '0;
    query_x     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_MODE;
    cfg_data    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset
    send_item(REQ_QUERY, 6'($urandom), $urandom, $urandom, Q_MIN);
    send_item(REQ_QUERY, 6'($urandom), $urandom, $urandom, Q_MAX);

    // single point
    send_item(REQ_WRITE, 6'd0, -32'sd196608, Q_MIN, $urandom);
    wait_idle();
    configure({4'd0, MODE_CLAMP}, 7'd1);
    send_item(REQ_QUERY, 6'($urandom), $urandom, $urandom, 32'sd0);

    // steep four-point table; slot 63 lies beyond the count and is ignored
    send_item(REQ_WRITE, 6'd1, -32'sd65536, Q_MAX, $urandom);
    send_item(REQ_WRITE, 6'd2, 32'sd65536, -32'sd5, $urandom);
    send_item(REQ_WRITE, 6'd3, 32'sd262144, Q_MAX, $urandom);
    send_item(REQ_WRITE, 6'd63, Q_MAX, Q_MIN, $urandom);
    foreach (dir_modes[m]) begin
      wait_idle();
      configure({4'd0, dir_modes[m]}, 7'd4);
      foreach (dir_q[k]) send_item(REQ_QUERY, 6'($urandom), $urandom, $urandom, dir_q[k]);
    end

    items_left = RANDOM_ITEMS;
    phase      = 0;
    while (items_left > 0) begin
      mode3 = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
      case (phase)
        1: count = 7'd127;
        2: count = 7'd64;
        3: count = 7'd0;
        4: count = 7'd1;
        5: count = 7'd2;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 7) count = 7'($urandom_range(2, 10));
          else if (r == 7) count = 7'($urandom_range(11, 40));
          else if (r == 8) count = 7'($urandom_range(0, 1));
          else count = 7'($urandom_range(64, 127));
        end
      endcase
      n_eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

      wait_idle();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      configure({4'($urandom_range(0, 15)), mode3}, count);

      // ascending table, occasional repeated x, y wandering or jumping
      pick     = $urandom_range(0, 3);
      step_max = (pick == 0) ? 16 : (pick == 1) ? 65536 : (pick == 2) ? (1 << 20) : (1 << 24);
      xv       = -longint'($urandom_range(0, 1 << 30));
      if ($urandom_range(0, 7) == 0) xv = longint'(Q_MIN);
      yv       = $urandom;
      for (int i = 0; i < n_eff; i++) begin
        send_item(REQ_WRITE, 6'(i), 32'(xv), yv, $urandom);
        tab_x[i] = xv;
        if ($urandom_range(0, 7) != 0) xv += $urandom_range(1, step_max);
        if ($urandom_range(0, 1) == 0) yv = $urandom;
        else yv = yv + 32'($urandom_range(0, 131072)) - 32'sd65536;
      end
      items_left -= n_eff;

      phase_len = $urandom_range(60, 120);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          // stray write: any slot, may break the ordering of the table
          idx = 6'($urandom_range(0, TABLE_DEPTH - 1));
          if ($urandom_range(0, 1) == 0) px = $urandom;
          else px = 32'(tab_x[idx] + longint'($urandom_range(0, 4096)) - 2048);
          tab_x[idx] = px;
          send_item(REQ_WRITE, idx, px, $urandom, $urandom);
        end else begin
          r = $urandom_range(0, 19);
          if (n_eff == 0 || r >= 16) begin
            qx = $urandom;
          end else begin
            lo = tab_x[0];
            hi = tab_x[n_eff-1];
            if (lo > hi) begin
              span = lo;
              lo   = hi;
              hi   = span;
            end
            if (r >= 12) begin
              qx = 32'(tab_x[$urandom_range(0, n_eff - 1)] + longint'($urandom_range(0, 2)) - 1);
            end else if (r == 11) begin
              qx = 32'(lo - longint'($urandom_range(1, 1 << 20)));
            end else if (r == 10) begin
              qx = 32'(hi + longint'($urandom_range(1, 1 << 20)));
            end else begin
              span = hi - lo;
              qx   = 32'(lo + longint'($urandom) % (span + 1));
            end
          end
          send_item(REQ_QUERY, 6'($urandom), $urandom, $urandom, qx);
        end
      end
      items_left -= phase_len;
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
